// File: src/sdmd_pkg.sv
// Shared types and constants of the sigma-delta motion detector.
`default_nettype none

package sdmd_pkg;

    // Default number of pixel positions held in the state memory
    localparam int PIXEL_COUNT_DEF = 65536;

    // Configuration reset values
    localparam logic [7:0] VMIN_RST = 8'd1;
    localparam logic [7:0] VMAX_RST = 8'd254;

    // Configuration port address width and register selects (paddr bit 2)
    localparam int PADDR_W = 3;
    localparam logic REG_VMIN = 1'b0;
    localparam logic REG_VMAX = 1'b1;

    // Saturation value of the doubled difference
    localparam logic [7:0] PIX_MAX = 8'd255;

    // One input transaction
    typedef struct packed {
        logic [7:0]  pixel;
        logic [15:0] pixel_index;
        logic        init;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic        motion;
        logic [7:0]  difference;
        logic [7:0]  background;
        logic [7:0]  variance;
    } t_out_item;

    // Per-pixel state word
    typedef struct packed {
        logic [7:0] background;
        logic [7:0] variance;
    } t_state;

    // Configuration registers
    typedef struct packed {
        logic [7:0] vmin;
        logic [7:0] vmax;
    } t_cfg;

endpackage

`default_nettype wire

// File: src/sdmd_cfg.sv
// APB-style configuration registers vmin and vmax.
`default_nettype none

module sdmd_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdmd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output sdmd_pkg::t_cfg                    o_cfg
);

    sdmd_pkg::t_cfg r_cfg;
    sdmd_pkg::t_cfg n_cfg;
    logic           wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite && pready;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_stb) begin
            unique case (paddr[2])
                sdmd_pkg::REG_VMIN: n_cfg.vmin = pwdata[7:0];
                sdmd_pkg::REG_VMAX: n_cfg.vmax = pwdata[7:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vmin <= sdmd_pkg::VMIN_RST;
            r_cfg.vmax <= sdmd_pkg::VMAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (paddr[2])
            sdmd_pkg::REG_VMIN: prdata = {24'd0, r_cfg.vmin};
            sdmd_pkg::REG_VMAX: prdata = {24'd0, r_cfg.vmax};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/sdmd_store.sv
// Per-pixel state memory with registered read and write-to-read forwarding.
`default_nettype none

module sdmd_store #(
    parameter int  PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF,
    localparam int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire sdmd_pkg::t_state i_wr_data,
    output sdmd_pkg::t_state      o_rd_data
);

    sdmd_pkg::t_state mem [PIXEL_COUNT];
    sdmd_pkg::t_state r_q;
    sdmd_pkg::t_state r_fwd_data;
    logic             r_fwd_hit;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // Capture a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// File: src/sdmd_update.sv
// Sigma-delta update of one pixel's background and variance.
`default_nettype none

module sdmd_update (
    input  wire logic [7:0]       i_pixel,
    input  wire logic             i_init,
    input  wire sdmd_pkg::t_state i_old,
    input  wire sdmd_pkg::t_cfg   i_cfg,
    output sdmd_pkg::t_out_item   o_result
);

    function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0] res;
        if (cur < tgt) begin
            res = cur + 8'd1;
        end else if (cur > tgt) begin
            res = cur - 8'd1;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    logic [7:0] bg;
    logic [7:0] diff;
    logic [7:0] dbl;
    logic [7:0] var_step;
    logic [7:0] var_hi;
    logic [7:0] var_clamp;

    // Step background, then form the difference and its saturated double
    always_comb begin
        bg   = step_toward(i_old.background, i_pixel);
        diff = (bg > i_pixel) ? (bg - i_pixel) : (i_pixel - bg);
        dbl  = diff[7] ? sdmd_pkg::PIX_MAX : {diff[6:0], 1'b0};
    end

    // Step variance, clamp to vmax first and vmin last
    always_comb begin
        var_step  = step_toward(i_old.variance, dbl);
        var_hi    = (var_step > i_cfg.vmax) ? i_cfg.vmax : var_step;
        var_clamp = (var_hi < i_cfg.vmin) ? i_cfg.vmin : var_hi;
    end

    // Select the init result or the update result
    always_comb begin
        if (i_init) begin
            o_result.motion     = 1'b0;
            o_result.difference = 8'd0;
            o_result.background = i_pixel;
            o_result.variance   = i_cfg.vmin;
        end else begin
            o_result.motion     = (diff >= var_clamp);
            o_result.difference = diff;
            o_result.background = bg;
            o_result.variance   = var_clamp;
        end
    end

endmodule

`default_nettype wire

// File: src/sigma_delta_motion_detect.sv
// Stage 1 holds the input and state read; the output register holds the update. One pixel
// per cycle unless the output stalls; the state memory is read and written once per in-range
// pixel, with a forwarding register covering a pixel that follows one at the same position.
// Reset: synchronous active-low; clears the pipeline valids and sets vmin=1, vmax=254.
// Memory is not cleared; the user must send each position an init pixel first, unenforced.
`default_nettype none

module sigma_delta_motion_detect #(
    parameter int PIXEL_COUNT = sdmd_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire sdmd_pkg::t_in_item           i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output sdmd_pkg::t_out_item               o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdmd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    sdmd_pkg::t_cfg      cfg;
    sdmd_pkg::t_state    rd_data;
    sdmd_pkg::t_state    old_state;
    sdmd_pkg::t_state    wr_data;
    sdmd_pkg::t_out_item result;

    logic [31:0]   idx_ext;
    logic          in_range;
    logic          accept;
    logic          s1_adv;
    logic          rd_en;
    logic          wr_en;

    logic          r_s1_valid;
    logic [7:0]    r_s1_pixel;
    logic          r_s1_init;
    logic          r_s1_inr;
    logic [AW-1:0] r_s1_addr;

    sdmd_pkg::t_out_item r_out_data;
    logic                r_out_valid;

    sdmd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Address decode of the incoming transaction
    assign idx_ext  = 32'(i_in_data.pixel_index);
    assign in_range = idx_ext < 32'(PIXEL_COUNT);

    // Handshake: stage 1 moves on when the output register is free or drains
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign rd_en      = accept && in_range;
    assign wr_en      = s1_adv && r_s1_inr;

    sdmd_store #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (idx_ext[AW-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_in_data.pixel;
            r_s1_init  <= i_in_data.init;
            r_s1_inr   <= in_range;
            r_s1_addr  <= idx_ext[AW-1:0];
        end
    end

    // Out-of-range positions see zero state
    assign old_state = r_s1_inr ? rd_data : '0;

    sdmd_update u_update (
        .i_pixel  (r_s1_pixel),
        .i_init   (r_s1_init),
        .i_old    (old_state),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign wr_data.background = result.background;
    assign wr_data.variance   = result.variance;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A stalled stage 1 transaction keeps its place and its address
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("stage 1 transaction lost while stalled");

    // The clamped variance never falls below vmin
    a_var_floor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (result.variance >= cfg.vmin))
        else $error("variance below vmin");

    // An init pixel reports no motion and zero difference
    a_init_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_init) |-> (!result.motion && (result.difference == 8'd0)))
        else $error("init pixel produced motion");

endmodule

`default_nettype wire
